// ===== rtl/timer_min_heap_queue_defines.svh =====
// Assertion macros for the timer heap queue.
// Included by the top level; no other dependencies.
`ifndef TIMER_MIN_HEAP_QUEUE_DEFINES_SVH
`define TIMER_MIN_HEAP_QUEUE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define TMHQ_ASSERT_SAME(lbl, ante, cons) lbl: assert property (@(posedge clock) \
   disable iff (reset) (ante) |-> (cons)) else $error("tmhq assertion failed");
`define TMHQ_ASSERT_NEXT(lbl, ante, cons) lbl: assert property (@(posedge clock) \
   disable iff (reset) (ante) |=> (cons)) else $error("tmhq assertion failed");
`else
`define TMHQ_ASSERT_SAME(lbl, ante, cons)
`define TMHQ_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/tmhq_pkg.sv =====
// Shared types and constants of the timer heap queue.
// No dependencies.
`timescale 1ns / 1ps
package tmhq_pkg;
   localparam int MAX_TIMERS   = 64;
   localparam int HANDLE_SLOTS = 256;
   localparam int TIME_BITS    = 48;
   localparam int IDX_W  = $clog2(MAX_TIMERS);
   localparam int CNT_W  = $clog2(MAX_TIMERS + 1);
   localparam int SLOT_W = $clog2(HANDLE_SLOTS);
   localparam int HDL_W  = 8;
   localparam int TOUT_W = 31;

   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_POP    = 2'd2;
   localparam logic [1:0] OP_NEXT   = 2'd3;

   localparam logic [2:0] ST_OK     = 3'd0;
   localparam logic [2:0] ST_FULL   = 3'd1;
   localparam logic [2:0] ST_ABSENT = 3'd2;
   localparam logic [2:0] ST_EMPTY  = 3'd3;
   localparam logic [2:0] ST_BADHDL = 3'd4;

   typedef struct packed {
      logic [1:0]       op;
      logic [HDL_W-1:0] handle;
      logic [47:0]      time_ms;
   } req_type;

   typedef struct packed {
      logic [HDL_W-1:0]  handle_out;
      logic [TOUT_W-1:0] timeout_ms;
      logic [2:0]        status;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic [TIME_BITS-1:0] expiry;
      logic [HDL_W-1:0]     handle;
   } entry_type;
endpackage

// ===== rtl/timer_min_heap_queue.sv =====
// Top level of the indexed min-heap timer queue.
// Depends on tmhq_pkg, tmhq_ram and timer_min_heap_queue_defines.svh.
`timescale 1ns / 1ps
`include "timer_min_heap_queue_defines.svh"

// Timer queue: a binary min-heap of (expiry, handle) entries in one RAM, and
// a handle-to-slot table in a second RAM with a present bit per handle in
// flops. An item is taken when start is high and busy is low; busy stays high
// until the last result of the item is shown. Each result appears on rsp_data
// for exactly one cycle with rsp_strobe high and must be captured then: the
// block never waits on the receiver. The heap is walked through a single read
// port with registered read data, so a sift level going down reads the left
// child, then the right child, then moves the smaller child up if it is
// earlier; going up it reads the parent, then moves it down. A pop repeats a
// full removal for every expired handle. No clearing pass is needed after
// reset.
module timer_min_heap_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  tmhq_pkg::req_type req_data,
   output logic             rsp_strobe,
   output tmhq_pkg::rsp_type rsp_data
);
   import tmhq_pkg::*;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_POS     = 4'd1;
   localparam logic [3:0] S_LASTRD  = 4'd2;
   localparam logic [3:0] S_DN_CHK  = 4'd3;
   localparam logic [3:0] S_DN_L    = 4'd4;
   localparam logic [3:0] S_DN_R    = 4'd5;
   localparam logic [3:0] S_DN_MV   = 4'd6;
   localparam logic [3:0] S_UP_CHK  = 4'd7;
   localparam logic [3:0] S_UP_RD   = 4'd8;
   localparam logic [3:0] S_FIN     = 4'd9;
   localparam logic [3:0] S_ROOT    = 4'd10;

   // control state
   logic [3:0]              state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [HANDLE_SLOTS-1:0] present_ff, present_in;
   logic                    pend_ff, pend_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   // working registers
   logic [1:0]              op_ff, op_in;
   logic [TIME_BITS-1:0]    time_ff, time_in;
   logic [HDL_W-1:0]        hdl_ff, hdl_in;
   entry_type               cur_ff, cur_in;
   entry_type               best_ff, best_in;
   logic                    sel_ff, sel_in;
   logic [IDX_W:0]          bidx_ff, bidx_in;
   logic [IDX_W-1:0]        i_ff, i_in;
   logic [IDX_W-1:0]        start_ff, start_in;
   logic [HDL_W-1:0]        pend_hdl_ff, pend_hdl_in;
   rsp_type                 rsp_ff, rsp_in;

   // memory ports
   logic             heap_we;
   logic [IDX_W-1:0] heap_waddr, heap_raddr;
   entry_type        heap_wdata, heap_rdata;
   logic             pos_we;
   logic [SLOT_W-1:0] pos_waddr, pos_raddr;
   logic [IDX_W-1:0] pos_wdata, pos_rdata;

   tmhq_ram #(.WIDTH($bits(entry_type)), .DEPTH(MAX_TIMERS)) u_heap_ram (
      .clock (clock),
      .we    (heap_we),
      .waddr (heap_waddr),
      .wdata (heap_wdata),
      .raddr (heap_raddr),
      .rdata (heap_rdata)
   );

   tmhq_ram #(.WIDTH(IDX_W), .DEPTH(HANDLE_SLOTS)) u_pos_ram (
      .clock (clock),
      .we    (pos_we),
      .waddr (pos_waddr),
      .wdata (pos_wdata),
      .raddr (pos_raddr),
      .rdata (pos_rdata)
   );

   // child and parent indexes of the current slot
   logic [IDX_W+1:0] left_idx, right_idx, count_ext;
   logic [IDX_W-1:0] parent_idx, last_idx;
   logic [TIME_BITS:0] diff;

   assign left_idx   = {1'b0, i_ff, 1'b1};
   assign right_idx  = {1'b0, i_ff, 1'b0} + (IDX_W + 2)'(2);
   assign count_ext  = (IDX_W + 2)'(count_ff);
   assign parent_idx = (i_ff - IDX_W'(1)) >> 1;
   assign last_idx   = IDX_W'(count_ff - CNT_W'(1));
   assign diff       = {1'b0, heap_rdata.expiry} - {1'b0, time_ff};

   always_comb begin
      logic down_end;
      logic [CNT_W-1:0] last_cnt;
      entry_type root;
      down_end     = 1'b0;
      last_cnt     = count_ff - CNT_W'(1);
      root         = heap_rdata;
      state_in     = state_ff;
      count_in     = count_ff;
      present_in   = present_ff;
      pend_in      = pend_ff;
      pend_hdl_in  = pend_hdl_ff;
      op_in        = op_ff;
      time_in      = time_ff;
      hdl_in       = hdl_ff;
      cur_in       = cur_ff;
      best_in      = best_ff;
      sel_in       = sel_ff;
      bidx_in      = bidx_ff;
      i_in         = i_ff;
      start_in     = start_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      heap_we      = 1'b0;
      heap_waddr   = i_ff;
      heap_wdata   = cur_ff;
      heap_raddr   = '0;
      pos_we       = 1'b0;
      pos_waddr    = cur_ff.handle[SLOT_W-1:0];
      pos_wdata    = i_ff;
      pos_raddr    = req_data.handle[SLOT_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in   = req_data.op;
               time_in = req_data.time_ms[TIME_BITS-1:0];
               hdl_in  = req_data.handle;
               pend_in = 1'b0;
               unique case (req_data.op)
                  OP_ADD, OP_REMOVE: begin
                     if (int'(req_data.handle) >= HANDLE_SLOTS) begin
                        rsp_valid_in = 1'b1;
                        rsp_in.status = ST_BADHDL;
                        rsp_in.last = 1'b1;
                     end else if (present_ff[req_data.handle[SLOT_W-1:0]]) begin
                        state_in = S_POS;
                     end else if (req_data.op == OP_REMOVE) begin
                        rsp_valid_in = 1'b1;
                        rsp_in.status = ST_ABSENT;
                        rsp_in.last = 1'b1;
                     end else if (count_ff == CNT_W'(MAX_TIMERS)) begin
                        rsp_valid_in = 1'b1;
                        rsp_in.status = ST_FULL;
                        rsp_in.last = 1'b1;
                     end else begin
                        // new handle: open a slot at the bottom, sift up
                        cur_in.expiry = req_data.time_ms[TIME_BITS-1:0];
                        cur_in.handle = req_data.handle;
                        i_in     = IDX_W'(count_ff);
                        start_in = IDX_W'(count_ff);
                        count_in = count_ff + CNT_W'(1);
                        present_in[req_data.handle[SLOT_W-1:0]] = 1'b1;
                        state_in = S_UP_CHK;
                     end
                  end
                  default: begin
                     if (count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_in.status = ST_EMPTY;
                        rsp_in.last = 1'b1;
                     end else begin
                        heap_raddr = '0;
                        state_in = S_ROOT;
                     end
                  end
               endcase
            end
         end
         S_POS: begin
            if (op_ff == OP_ADD) begin
               cur_in.expiry = time_ff;
               cur_in.handle = hdl_ff;
               i_in     = pos_rdata;
               start_in = pos_rdata;
               state_in = S_DN_CHK;
            end else begin
               present_in[hdl_ff[SLOT_W-1:0]] = 1'b0;
               count_in = last_cnt;
               i_in     = pos_rdata;
               start_in = pos_rdata;
               if (pos_rdata == last_idx) begin
                  state_in = S_FIN;
               end else begin
                  heap_raddr = last_idx;
                  state_in = S_LASTRD;
               end
            end
         end
         S_LASTRD: begin
            cur_in   = heap_rdata;
            state_in = S_DN_CHK;
         end
         S_DN_CHK: begin
            sel_in = 1'b0;
            if (left_idx < count_ext) begin
               heap_raddr = left_idx[IDX_W-1:0];
               state_in = S_DN_L;
            end else begin
               down_end = 1'b1;
            end
         end
         S_DN_L: begin
            if (heap_rdata.expiry < cur_ff.expiry) begin
               best_in = heap_rdata;
               sel_in  = 1'b1;
               bidx_in = left_idx[IDX_W:0];
            end
            if (right_idx < count_ext) begin
               heap_raddr = right_idx[IDX_W-1:0];
               state_in = S_DN_R;
            end else begin
               state_in = S_DN_MV;
            end
         end
         S_DN_R: begin
            if (heap_rdata.expiry < (sel_ff ? best_ff.expiry : cur_ff.expiry)) begin
               best_in = heap_rdata;
               sel_in  = 1'b1;
               bidx_in = right_idx[IDX_W:0];
            end
            state_in = S_DN_MV;
         end
         S_DN_MV: begin
            if (sel_ff) begin
               // pull the smaller child into the hole
               heap_we    = 1'b1;
               heap_wdata = best_ff;
               pos_we     = 1'b1;
               pos_waddr  = best_ff.handle[SLOT_W-1:0];
               i_in       = bidx_ff[IDX_W-1:0];
               state_in   = S_DN_CHK;
            end else begin
               down_end = 1'b1;
            end
         end
         S_UP_CHK: begin
            if (i_ff == '0) begin
               heap_we  = 1'b1;
               pos_we   = 1'b1;
               state_in = S_FIN;
            end else begin
               heap_raddr = parent_idx;
               state_in = S_UP_RD;
            end
         end
         S_UP_RD: begin
            heap_we = 1'b1;
            pos_we  = 1'b1;
            if (cur_ff.expiry < heap_rdata.expiry) begin
               heap_wdata = heap_rdata;
               pos_waddr  = heap_rdata.handle[SLOT_W-1:0];
               i_in       = parent_idx;
               state_in   = S_UP_CHK;
            end else begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (op_ff == OP_POP) begin
               if (count_ff == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_in.handle_out = pend_hdl_ff;
                  rsp_in.last = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  heap_raddr = '0;
                  state_in = S_ROOT;
               end
            end else begin
               rsp_valid_in = 1'b1;
               rsp_in.status = ST_OK;
               rsp_in.last = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_ROOT: begin
            state_in = S_IDLE;
            if (op_ff == OP_NEXT) begin
               rsp_valid_in = 1'b1;
               rsp_in.last = 1'b1;
               if (heap_rdata.expiry > time_ff) begin
                  rsp_in.timeout_ms = (diff > (TIME_BITS + 1)'({TOUT_W{1'b1}})) ?
                                      {TOUT_W{1'b1}} : diff[TOUT_W-1:0];
               end
            end else if (root.expiry <= time_ff) begin
               // emit the held handle, hold the new root and take it out
               if (pend_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_in.handle_out = pend_hdl_ff;
               end
               pend_in     = 1'b1;
               pend_hdl_in = root.handle;
               present_in[root.handle[SLOT_W-1:0]] = 1'b0;
               count_in = last_cnt;
               i_in     = '0;
               start_in = '0;
               if (last_cnt == '0) begin
                  state_in = S_FIN;
               end else begin
                  heap_raddr = last_idx;
                  state_in = S_LASTRD;
               end
            end else begin
               rsp_valid_in = 1'b1;
               rsp_in.last = 1'b1;
               if (pend_ff) begin
                  rsp_in.handle_out = pend_hdl_ff;
               end else begin
                  rsp_in.status = ST_EMPTY;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // end of a sift down: sift up only if the entry never moved
      if (down_end) begin
         if (i_ff == start_ff) begin
            state_in = S_UP_CHK;
         end else begin
            heap_we  = 1'b1;
            pos_we   = 1'b1;
            state_in = S_FIN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         present_ff   <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         present_ff   <= present_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      time_ff     <= time_in;
      hdl_ff      <= hdl_in;
      cur_ff      <= cur_in;
      best_ff     <= best_in;
      sel_ff      <= sel_in;
      bidx_ff     <= bidx_in;
      i_ff        <= i_in;
      start_ff    <= start_in;
      pend_hdl_ff <= pend_hdl_in;
      rsp_ff      <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   `TMHQ_ASSERT_SAME(a_last_idle, rsp_strobe && rsp_data.last, !busy)
   `TMHQ_ASSERT_SAME(a_count_max, 1'b1, count_ff <= CNT_W'(MAX_TIMERS))
   `TMHQ_ASSERT_NEXT(a_accept_progress, start && !busy, busy || rsp_strobe)
   `TMHQ_ASSERT_SAME(a_write_in_heap, heap_we, (CNT_W)'(heap_waddr) < count_ff)
endmodule

// ===== rtl/tmhq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module tmhq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
